>>> src/bskt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bskt_pkg: shared types and constants of the bounded sorted key table
// Field widths, function codes, beat payload structs, sequencer states and
// the control groups passed between the sequencer and the compare unit.
// ----------------------------------------------------------------------------
package bskt_pkg;

   localparam int KEY_W     = 31;
   localparam int SLOT_W    = 4;
   localparam int FUNC_W    = 2;
   localparam int COUNT_W   = 5;
   localparam int COUNT_MAX = 31;

   // function codes carried by a request beat
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               evicted;
      logic [KEY_W-1:0]   evicted_key;
      logic               delete_request;
      logic [COUNT_W-1:0] entry_count;
      logic [KEY_W-1:0]   read_key;
      logic               read_valid;
   } rsp_type;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } rsp_beat_type;

   // control of the shared compare-and-carry unit
   typedef struct packed {
      logic init;
      logic shift;
   } step_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

>>> src/bskt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bskt_mem: key storage
// One write port and one read port, read data registered. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
module bskt_mem
   import bskt_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [KEY_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] mem_ff [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bskt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bskt_step: shared compare-and-carry unit
// Merges the new key into the stream of stored keys, one slot per cycle.
// Before the insertion point each key is written back unchanged; at the
// first key above the new one the new key goes out and every later slot
// takes the key carried from the slot before it.
// ----------------------------------------------------------------------------
module bskt_step
   import bskt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  step_ctl_type     ctl,
   input  logic [KEY_W-1:0] new_key,
   input  logic [KEY_W-1:0] data,
   output logic [KEY_W-1:0] wr_value,
   output logic [KEY_W-1:0] tail_value
);

   logic             placed_ff;
   logic [KEY_W-1:0] carry_ff;
   logic             above;

   // new key goes after stored keys equal to it
   assign above      = (data > new_key);
   assign wr_value   = placed_ff ? carry_ff : (above ? new_key : data);
   assign tail_value = placed_ff ? carry_ff : new_key;

   // track whether the new key is already placed
   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         placed_ff <= 1'b0;
      end else if (ctl.shift) begin
         placed_ff <= placed_ff | above;
      end
   end

   // carry the displaced key one slot up
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         carry_ff <= data;
      end
   end

endmodule

>>> src/bskt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bskt_seq: request sequencer
// Decodes a request beat, keeps the count and last key, walks the stored
// keys through the compare unit on an insert and builds the result.
// ----------------------------------------------------------------------------
module bskt_seq
   import bskt_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic             keep_evicted,
   input  logic             out_free,
   output rsp_beat_type     done,
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output logic [KEY_W-1:0] mem_wr_data,
   output logic             mem_rd_en,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  logic [KEY_W-1:0] mem_rd_data,
   output step_ctl_type     step_ctl,
   output logic [KEY_W-1:0] step_key,
   input  logic [KEY_W-1:0] step_wr_value,
   input  logic [KEY_W-1:0] step_tail
);

   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int SAT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0] last_ff, last_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             off_ff, off_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   rsp_type          res_ff, res_in;

   logic             full;
   logic             scan_end;
   logic             slot_ok;
   logic [CMP_W-1:0] slot_ext;
   logic [IDX_W-1:0] slot_idx;
   logic [CNT_W-1:0] tail_pos;
   logic [SAT_W-1:0] count_ext;
   logic [COUNT_W-1:0] count_out;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign scan_end  = !pend_ff && (ptr_ff == count_ff);
   assign slot_ext  = CMP_W'(req_data.slot);
   assign slot_idx  = slot_ext[IDX_W-1:0];
   assign slot_ok   = (slot_ext < CMP_W'(count_ff));
   assign tail_pos  = count_ff - CNT_W'(off_ff);
   assign count_ext = SAT_W'(count_ff);
   assign count_out = (count_ext > SAT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                      : count_ext[COUNT_W-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign step_key  = key_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  FN_INSERT: state_in = (req_data.key == last_ff) ? ST_RESP : ST_SCAN;
                  FN_READ:   state_in = slot_ok ? ST_READ : ST_RESP;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and register next values
   always_comb begin
      count_in    = count_ff;
      last_in     = last_ff;
      key_in      = key_ff;
      off_in      = off_ff;
      ptr_in      = ptr_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = step_wr_value;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      step_ctl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in = req_data.key;
               off_in = full;
               ptr_in = '0;
               res_in = '0;
               case (req_data.func)
                  FN_CLEAR: begin
                     count_in = '0;
                     last_in  = '0;
                  end
                  FN_INSERT: begin
                     if (req_data.key != last_ff) begin
                        last_in               = req_data.key;
                        res_in.accepted       = 1'b1;
                        res_in.evicted        = full;
                        res_in.delete_request = full & ~keep_evicted;
                        step_ctl.init         = 1'b1;
                     end
                  end
                  FN_READ: begin
                     if (slot_ok) begin
                        mem_rd_en         = 1'b1;
                        mem_rd_addr       = slot_idx;
                        res_in.read_valid = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            res_in.read_key = mem_rd_data;
         end
         ST_SCAN: begin
            // fetch the next stored key
            if (ptr_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pidx_in     = ptr_ff[IDX_W-1:0];
            end
            // merge the fetched key, or capture slot 0 when evicting
            if (pend_ff) begin
               if (off_ff && (pidx_ff == '0)) begin
                  res_in.evicted_key = mem_rd_data;
               end else begin
                  step_ctl.shift = 1'b1;
                  mem_wr_en      = 1'b1;
                  mem_wr_addr    = pidx_ff - IDX_W'(off_ff);
               end
            end
            // write the last key of the merged run
            if (scan_end) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = tail_pos[IDX_W-1:0];
               mem_wr_data = step_tail;
               count_in    = off_ff ? count_ff : count_ff + CNT_W'(1);
            end
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   // hand the finished result to the output register
   always_comb begin
      done.valid           = (state_ff == ST_RESP) && out_free;
      done.rsp             = res_ff;
      done.rsp.entry_count = count_out;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         last_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         pend_ff  <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      off_ff  <= off_in;
      ptr_ff  <= ptr_in;
      pidx_ff <= pidx_in;
      res_ff  <= res_in;
   end

endmodule

>>> src/bounded_sorted_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sorted_key_table: sorted key table with evict-smallest on overflow
//
//   channel | direction | beat                      | when taken
//   req_    | in        | func, key, slot (req_type) | req_valid && req_ready
//   rsp_    | out       | result (rsp_type)          | rsp_valid && rsp_ready
//   csr_    | in        | keep_evicted (1 bit)       | csr_valid && csr_ready
//
// An insert of a new key walks the stored keys through one compare-and-carry
// unit, one slot per cycle; a read of a stored slot passes through the read
// state; clear, repeated keys, unused codes and reads beyond the count go
// straight to the result. The sequencer takes the next request in the cycle
// after its result is loaded. Reset is synchronous; it clears count and last
// key. A stalled result holds the next one in the sequencer.
// ----------------------------------------------------------------------------
module bounded_sorted_key_table
   import bskt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic             keep_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic             out_free;
   rsp_beat_type     done;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [KEY_W-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [KEY_W-1:0] mem_rd_data;
   step_ctl_type     step_ctl;
   logic [KEY_W-1:0] step_key;
   logic [KEY_W-1:0] step_wr_value;
   logic [KEY_W-1:0] step_tail;

   // take the keep flag on every csr beat
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b0;
      end else if (csr_valid) begin
         keep_ff <= csr_wdata;
      end
   end

   // hold the result until the consumer takes it
   assign out_free = !rsp_valid_ff || rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_data_ff <= done.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bskt_seq #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .keep_evicted  (keep_ff),
      .out_free      (out_free),
      .done          (done),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .step_ctl      (step_ctl),
      .step_key      (step_key),
      .step_wr_value (step_wr_value),
      .step_tail     (step_tail)
   );

   bskt_step u_step (
      .clock      (clock),
      .reset      (reset),
      .ctl        (step_ctl),
      .new_key    (step_key),
      .data       (mem_rd_data),
      .wr_value   (step_wr_value),
      .tail_value (step_tail)
   );

   bskt_mem #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

>>> src/bskt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bskt_checker: port-level checks of the sorted key table
// Watches the result channel for a held beat and for consistent flags.
// ----------------------------------------------------------------------------
module bskt_checker
   import bskt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam int CAP_SAT = (CAPACITY > COUNT_MAX) ? COUNT_MAX : CAPACITY;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // an eviction only comes from a stored insert on a full table
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |->
         rsp_data.accepted && (rsp_data.entry_count == COUNT_W'(CAP_SAT)))
      else $error("eviction without a stored insert on a full table");

   // delete request only on an eviction
   a_delete_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.delete_request |-> rsp_data.evicted)
      else $error("delete request without eviction");

   // a read beat never reports an insert
   a_read_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_valid |-> !rsp_data.accepted && !rsp_data.evicted)
      else $error("read result carries insert flags");

   // count never exceeds the table size
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= COUNT_W'(CAP_SAT)))
      else $error("entry count above capacity");

endmodule

bind bounded_sorted_key_table bskt_checker #(
   .CAPACITY (CAPACITY)
) u_bskt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the bounded sorted key table
// Drives clear, insert, read and unused-code beats through the request
// channel under several sender and receiver idle mixes. The keep flag is
// written before each phase. A scoreboard keeps its own sorted copy of the
// table and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module testbench
   import bskt_pkg::*;
;

   localparam int CAPACITY    = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_ITEMS = 300;
   localparam int MAX_PRINTS  = 40;

   // code with no function; the block answers it without touching state
   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

   // -------------------------------------------------------------------------
   // scoreboard: sorted-table predictor and in-order result check
   // -------------------------------------------------------------------------
   class key_table_scoreboard;
      logic [KEY_W-1:0] keys [CAPACITY];
      int               stored_count;
      logic [KEY_W-1:0] last_key;
      logic             keep_evicted;
      rsp_type          expected_rsp_q [$];
      int               mismatch_count;

      function new();
         stored_count   = 0;
         last_key       = '0;
         keep_evicted   = 1'b0;
         mismatch_count = 0;
         foreach (keys[i]) keys[i] = '0;
      endfunction

      task report(string msg);
         if (mismatch_count < MAX_PRINTS)
            $display("%0t ns mismatch: %s", $realtime, msg);
         mismatch_count++;
      endtask

      function void set_keep(logic value);
         keep_evicted = value;
      endfunction

      // apply one request to the table copy and return the result it gives
      function rsp_type sorted_table_step(req_type r);
         rsp_type res;
         int      pos;
         res = '0;
         case (r.func)
            FN_CLEAR: begin
               stored_count = 0;
               last_key     = '0;
            end
            FN_INSERT: begin
               if (r.key != last_key) begin
                  last_key     = r.key;
                  res.accepted = 1'b1;
                  // full table: drop the smallest key first
                  if (stored_count >= CAPACITY) begin
                     res.evicted        = 1'b1;
                     res.evicted_key    = keys[0];
                     res.delete_request = !keep_evicted;
                     for (int i = 1; i < CAPACITY; i++) keys[i-1] = keys[i];
                     stored_count = CAPACITY - 1;
                  end
                  // place after any equal keys
                  pos = stored_count;
                  while (pos > 0 && keys[pos-1] > r.key) begin
                     keys[pos] = keys[pos-1];
                     pos--;
                  end
                  keys[pos] = r.key;
                  stored_count++;
               end
            end
            FN_READ: begin
               if (int'(r.slot) < stored_count) begin
                  res.read_valid = 1'b1;
                  res.read_key   = keys[r.slot];
               end
            end
            default: ;
         endcase
         res.entry_count = (stored_count > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
                                                      : stored_count[COUNT_W-1:0];
         return res;
      endfunction

      function void note_request(req_type r);
         expected_rsp_q.push_back(sorted_table_step(r));
      endfunction

      task check_result(rsp_type got);
         rsp_type exp;
         if (expected_rsp_q.size() == 0) begin
            report($sformatf("result beat with nothing expected: %h", got));
            return;
         end
         exp = expected_rsp_q.pop_front();
         if (got.accepted !== exp.accepted)
            report($sformatf("accepted %b, expected %b", got.accepted, exp.accepted));
         if (got.evicted !== exp.evicted)
            report($sformatf("evicted %b, expected %b", got.evicted, exp.evicted));
         if (got.evicted_key !== exp.evicted_key)
            report($sformatf("evicted_key %h, expected %h",
                             got.evicted_key, exp.evicted_key));
         if (got.delete_request !== exp.delete_request)
            report($sformatf("delete_request %b, expected %b",
                             got.delete_request, exp.delete_request));
         if (got.entry_count !== exp.entry_count)
            report($sformatf("entry_count %0d, expected %0d",
                             got.entry_count, exp.entry_count));
         if (got.read_key !== exp.read_key)
            report($sformatf("read_key %h, expected %h", got.read_key, exp.read_key));
         if (got.read_valid !== exp.read_valid)
            report($sformatf("read_valid %b, expected %b", got.read_valid, exp.read_valid));
      endtask

      function int pending();
         return expected_rsp_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block signals
   // -------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_wdata = 1'b0;

   key_table_scoreboard sb = new();

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_go       = 1'b0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;

   // generator-side history used to bias keys toward repeats and equals
   logic [KEY_W-1:0] gen_last_key = '0;
   logic [KEY_W-1:0] gen_recent [8];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bounded_sorted_key_table #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // monitor: note accepted requests, check accepted results
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_keep(csr_wdata);
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // receiver: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left = HOLD_CYCLES;
         hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("bounded_sorted_key_table regression: fail");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------
   // offer one request beat, hold it until taken, then idle at random
   task send_req(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, logic [SLOT_W-1:0] s);
      req_type item;
      int      gap;
      item.func = f;
      item.key  = k;
      item.slot = s;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task write_keep(logic value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // step past the last accept edge so the monitor has noted it, then drain
   task wait_drained();
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // random key: repeats, recent keys, small values, extremes or full range
   function logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 12) return gen_last_key;
      if (r < 27) return gen_recent[$urandom_range(7)];
      if (r < 50) return KEY_W'($urandom_range(63));
      if (r < 53) return '1;
      return KEY_W'($urandom);
   endfunction

   task send_random();
      int               r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(99);
      k = pick_key();
      if (r < 3) begin
         send_req(FN_CLEAR, k, SLOT_W'($urandom));
      end else if (r < 6) begin
         send_req(FN_UNUSED, k, SLOT_W'($urandom));
      end else if (r < 34) begin
         send_req(FN_READ, k, SLOT_W'($urandom));
      end else begin
         gen_last_key = k;
         gen_recent[$urandom_range(7)] = k;
         send_req(FN_INSERT, k, SLOT_W'($urandom));
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      int   sender_pct [5];
      int   stall_pct  [5];
      logic keep_of    [5];

      sender_pct = '{0, 49, 0, 23, 0};
      stall_pct  = '{0, 0, 49, 23, 0};
      keep_of    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      foreach (gen_recent[i]) gen_recent[i] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_keep(1'b0);

      // directed: repeats, extremes, equal keys, unused code, full-table evict
      send_req(FN_CLEAR, '0, '0);
      send_req(FN_INSERT, '0, '0);
      send_req(FN_READ, '0, '1);
      send_req(FN_INSERT, '1, '0);
      send_req(FN_INSERT, '1, '0);
      send_req(FN_INSERT, KEY_W'(1), '0);
      send_req(FN_INSERT, KEY_W'(5), '0);
      send_req(FN_INSERT, KEY_W'(9), '0);
      send_req(FN_INSERT, KEY_W'(5), '0);
      send_req(FN_UNUSED, '1, '1);
      for (int i = 0; i < 11; i++) send_req(FN_INSERT, KEY_W'(1000 + 37 * i), '0);
      send_req(FN_INSERT, '0, '0);
      send_req(FN_READ, '0, '0);
      send_req(FN_READ, '0, '1);
      send_req(FN_CLEAR, '1, '1);
      req_valid <= 1'b0;

      // random phases over idle mixes and both keep settings
      for (int p = 0; p < 5; p++) begin
         wait_drained();
         write_keep(keep_of[p]);
         send_idle_pct = sender_pct[p];
         rsp_stall_pct = stall_pct[p];
         // first phase: hold the receiver off so the block backs up
         if (p == 0) hold_go = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (4 * CAPACITY) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("bounded_sorted_key_table regression: pass");
      end else begin
         $display("bounded_sorted_key_table regression: fail");
      end
      $finish;
   end

endmodule
